>>> rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants of the C comment and space stripper.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int unsigned CharW = 8;
    localparam int unsigned KindW = 2;

    localparam logic [KindW-1:0] KIND_CHAR = 2'd0;
    localparam logic [KindW-1:0] KIND_LINE = 2'd1;
    localparam logic [KindW-1:0] KIND_END  = 2'd2;

    localparam logic [CharW-1:0] CH_CR    = 8'd13;
    localparam logic [CharW-1:0] CH_LF    = 8'd10;
    localparam logic [CharW-1:0] CH_DQUOTE = 8'd34;
    localparam logic [CharW-1:0] CH_SQUOTE = 8'd39;
    localparam logic [CharW-1:0] CH_SLASH = 8'd47;
    localparam logic [CharW-1:0] CH_STAR  = 8'd42;
    localparam logic [CharW-1:0] CH_SPACE = 8'd32;
    localparam logic [CharW-1:0] CH_TAB   = 8'd9;

    // Results caused by one request, delivered in the order char, line, end.
    typedef struct packed {
        logic             has_char;
        logic [CharW-1:0] char_value;
        logic             has_line;
        logic             has_end;
    } t_res;

endpackage

>>> rtl/ccs_core.sv
// ----------------------------------------------------------------------------
// ccs_core
// Comment and blank state per line; computes the results of one request.
// ----------------------------------------------------------------------------
module ccs_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [ccs_pkg::CharW-1:0] i_byte,
    input  logic                      i_eot,
    output ccs_pkg::t_res             o_res
);

    typedef struct packed {
        logic skip;
        logic cq;
        logic ibc;
        logic sq;
        logic bs;
        logic le;
    } t_flags;

    typedef struct packed {
        t_flags flags;
        logic   consumed;
        logic   emit;
    } t_stage;

    localparam t_flags FlagsReset = '{skip: 1'b0, cq: 1'b0, ibc: 1'b0,
                                      sq: 1'b0, bs: 1'b1, le: 1'b0};

    function automatic t_stage comment_stage(
        input logic [ccs_pkg::CharW-1:0] c,
        input logic                      has_next,
        input logic [ccs_pkg::CharW-1:0] nx,
        input t_flags                    f
    );
        t_stage s;
        logic   blank;
        s          = '0;
        s.flags    = f;
        blank      = (c == ccs_pkg::CH_SPACE) || (c == ccs_pkg::CH_TAB);
        s.flags.cq = f.cq ^ (c == ccs_pkg::CH_DQUOTE);
        if (!s.flags.cq && has_next && c == ccs_pkg::CH_SLASH && nx == ccs_pkg::CH_SLASH) begin
            s.flags.skip = 1'b1;
            s.consumed   = 1'b1;
        end else if (!s.flags.cq && has_next && c == ccs_pkg::CH_SLASH &&
                     nx == ccs_pkg::CH_STAR) begin
            s.flags.ibc = 1'b1;
            s.consumed  = 1'b1;
        end else if (!s.flags.cq && has_next && c == ccs_pkg::CH_STAR &&
                     nx == ccs_pkg::CH_SLASH) begin
            s.flags.ibc = 1'b0;
            s.consumed  = 1'b1;
        end else if (!f.ibc) begin
            s.flags.sq = f.sq ^ ((c == ccs_pkg::CH_DQUOTE) || (c == ccs_pkg::CH_SQUOTE));
            if (!s.flags.sq && blank) begin
                if (!f.bs) begin
                    s.emit       = 1'b1;
                    s.flags.le   = 1'b1;
                    s.flags.bs   = 1'b1;
                end
            end else begin
                s.emit     = 1'b1;
                s.flags.le = 1'b1;
                s.flags.bs = 1'b0;
            end
        end
        return s;
    endfunction

    t_flags                    r_flags, n_flags;
    logic                      r_held_valid, n_held_valid;
    logic [ccs_pkg::CharW-1:0] r_held_char, n_held_char;
    t_stage                    w_stage;
    logic                      w_line_end;

    assign w_line_end = (i_byte == ccs_pkg::CH_CR) || (i_byte == ccs_pkg::CH_LF);

    always_comb begin
        n_flags      = r_flags;
        n_held_valid = r_held_valid;
        n_held_char  = r_held_char;
        o_res        = '0;
        w_stage      = comment_stage(r_held_char, !(i_eot || w_line_end), i_byte, r_flags);
        if (i_eot || w_line_end) begin
            if (r_held_valid && !r_flags.skip) begin
                o_res.has_char   = w_stage.emit;
                o_res.char_value = r_held_char;
                o_res.has_line   = w_stage.flags.le;
                n_flags.ibc      = w_stage.flags.ibc;
            end else begin
                o_res.has_line   = r_flags.le;
            end
            o_res.has_end = i_eot;
            n_flags.skip  = FlagsReset.skip;
            n_flags.cq    = FlagsReset.cq;
            n_flags.sq    = FlagsReset.sq;
            n_flags.bs    = FlagsReset.bs;
            n_flags.le    = FlagsReset.le;
            if (i_eot) begin
                n_flags.ibc = FlagsReset.ibc;
            end
            n_held_valid = 1'b0;
            n_held_char  = '0;
        end else if (r_flags.skip) begin
            n_flags = r_flags;
        end else if (r_held_valid) begin
            o_res.has_char   = w_stage.emit;
            o_res.char_value = r_held_char;
            n_flags          = w_stage.flags;
            if (w_stage.consumed) begin
                n_held_valid = 1'b0;
                n_held_char  = '0;
            end else begin
                n_held_char  = i_byte;
            end
        end else begin
            n_held_valid = 1'b1;
            n_held_char  = i_byte;
        end
        if (!o_res.has_char) begin
            o_res.char_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags      <= FlagsReset;
            r_held_valid <= 1'b0;
            r_held_char  <= '0;
        end else if (i_accept) begin
            r_flags      <= n_flags;
            r_held_valid <= n_held_valid;
            r_held_char  <= n_held_char;
        end
    end

endmodule

>>> rtl/c_comment_and_space_stripper.sv
// ----------------------------------------------------------------------------
// c_comment_and_space_stripper
// Streaming remover of C comments, leading blanks and repeated blanks.
// ----------------------------------------------------------------------------
// The slave stream carries one source byte per request in s_axis_tdata, with
// s_axis_tlast marking end of text. The master stream returns kept
// characters (tuser 0), ends of non-empty lines (tuser 1) and the end of
// text (tuser 2); tlast marks the final result caused by one request.
// One byte is held back internally so that two-character comment markers
// can be seen, so a kept character appears on the request after it.
// Results of a request are registered and appear in the cycle after it is
// accepted. A request that causes one result or none is taken every cycle
// while the receiver is ready; one that causes two or three results holds
// the single output register until all have left, draining one per cycle.
// The input is taken in the cycle that the last pending result leaves,
// so there is no bubble while the receiver keeps m_axis_tready high.
// When the receiver stalls, the pending results hold and s_axis_tready drops.
// Synchronous reset clears all line and comment state and empties the output.
module c_comment_and_space_stripper (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [ccs_pkg::CharW-1:0] s_axis_tdata,  // input_byte
    input  logic                      s_axis_tlast,  // end_of_text
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [ccs_pkg::CharW-1:0] m_axis_tdata,  // char_value
    output logic [ccs_pkg::KindW-1:0] m_axis_tuser,  // kind
    output logic                      m_axis_tlast   // last_of_run
);

    ccs_pkg::t_res r_res, n_res;
    ccs_pkg::t_res w_new;
    logic          w_accept;
    logic          w_single;
    logic          w_pop;

    assign w_single      = $countones({r_res.has_char, r_res.has_line, r_res.has_end}) == 1;
    assign w_pop         = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = r_res.has_char || r_res.has_line || r_res.has_end;
    assign s_axis_tready = !m_axis_tvalid || (w_single && m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    ccs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata),
        .i_eot    (s_axis_tlast),
        .o_res    (w_new)
    );

    always_comb begin
        m_axis_tlast = w_single;
        if (r_res.has_char) begin
            m_axis_tuser = ccs_pkg::KIND_CHAR;
            m_axis_tdata = r_res.char_value;
        end else if (r_res.has_line) begin
            m_axis_tuser = ccs_pkg::KIND_LINE;
            m_axis_tdata = '0;
        end else begin
            m_axis_tuser = ccs_pkg::KIND_END;
            m_axis_tdata = '0;
        end
    end

    always_comb begin
        n_res = r_res;
        if (w_pop) begin
            if (r_res.has_char) begin
                n_res.has_char = 1'b0;
            end else if (r_res.has_line) begin
                n_res.has_line = 1'b0;
            end else begin
                n_res.has_end = 1'b0;
            end
        end
        if (w_accept) begin
            n_res = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
    end

endmodule

>>> rtl/ccs_checker.sv
// ----------------------------------------------------------------------------
// ccs_checker
// Port-level checks of the C comment and space stripper.
// ----------------------------------------------------------------------------
module ccs_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [ccs_pkg::CharW-1:0] m_axis_tdata,
    input logic [ccs_pkg::KindW-1:0] m_axis_tuser,
    input logic                      m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Output request dropped while stalled.");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ccs_pkg::KIND_CHAR ||
                           m_axis_tuser == ccs_pkg::KIND_LINE ||
                           m_axis_tuser == ccs_pkg::KIND_END))
        else $error("Illegal result kind.");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ccs_pkg::KIND_CHAR |-> m_axis_tdata == '0)
        else $error("Line or text end carries nonzero data.");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ccs_pkg::KIND_END |-> m_axis_tlast)
        else $error("End of text is not the last result of its request.");

    a_stall_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("Input stalled with no pending result.");

endmodule

bind c_comment_and_space_stripper ccs_checker u_ccs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the C comment and space stripper. Source bytes are sent on the
// slave stream under changing sender gaps and receiver stalls. Each accepted
// request updates a behavioral copy of the stripper, and every result on the
// master stream is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;
    import ccs_pkg::*;

    localparam int CycleLimit = 300000;
    localparam int DrainCycles = 8;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [CharW-1:0] ch;
        logic             last;
    } t_strip_res;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [CharW-1:0] s_axis_tdata;   // input_byte
    logic             s_axis_tlast;   // end_of_text
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [CharW-1:0] m_axis_tdata;   // char_value
    logic [KindW-1:0] m_axis_tuser;   // kind
    logic             m_axis_tlast;   // last_of_run

    t_strip_res strip_q[$];
    t_strip_res step_res[0:2];
    int         step_n;

    logic             hold_v;
    logic [CharW-1:0] hold_ch;
    logic             skip_line;
    logic             cq_open;
    logic             in_block;
    logic             sq_open;
    logic             blank_sup;
    logic             line_out;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int fail_cnt = 0;
    int req_cnt = 0;
    int res_cnt = 0;
    int cycles = 0;

    c_comment_and_space_stripper dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_strip_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            res_cnt++;
            if (strip_q.size() == 0) begin
                $error("unexpected result: kind %0d, char %0d", m_axis_tuser, m_axis_tdata);
                fail_cnt++;
            end else begin
                want = strip_q.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("kind mismatch: expected %0d, actual %0d", want.kind, m_axis_tuser);
                    fail_cnt++;
                end
                if (m_axis_tdata !== want.ch) begin
                    $error("char_value mismatch: expected %0d, actual %0d",
                           want.ch, m_axis_tdata);
                    fail_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_of_run mismatch: expected %0d, actual %0d",
                           want.last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    function automatic void reset_model();
        hold_v = 1'b0;
        hold_ch = '0;
        skip_line = 1'b0;
        cq_open = 1'b0;
        in_block = 1'b0;
        sq_open = 1'b0;
        blank_sup = 1'b1;
        line_out = 1'b0;
    endfunction

    function automatic void add_res(logic [KindW-1:0] kind, logic [CharW-1:0] ch);
        step_res[step_n] = '{kind: kind, ch: ch, last: 1'b0};
        step_n++;
    endfunction

    function automatic void blank_filter(logic [CharW-1:0] c);
        if (c == CH_DQUOTE || c == CH_SQUOTE) sq_open = !sq_open;
        if (!sq_open && (c == CH_SPACE || c == CH_TAB)) begin
            if (!blank_sup) begin
                add_res(KIND_CHAR, c);
                line_out = 1'b1;
                blank_sup = 1'b1;
            end
            return;
        end
        blank_sup = 1'b0;
        add_res(KIND_CHAR, c);
        line_out = 1'b1;
    endfunction

    // Returns one when the following byte is part of a comment marker.
    function automatic bit comment_filter(logic [CharW-1:0] c, bit has_nx,
                                          logic [CharW-1:0] nx);
        if (c == CH_DQUOTE) cq_open = !cq_open;
        if (!cq_open && has_nx) begin
            if (c == CH_SLASH && nx == CH_SLASH) begin
                skip_line = 1'b1;
                return 1'b1;
            end
            if (c == CH_SLASH && nx == CH_STAR) begin
                in_block = 1'b1;
                return 1'b1;
            end
            if (c == CH_STAR && nx == CH_SLASH) begin
                in_block = 1'b0;
                return 1'b1;
            end
        end
        if (!in_block) blank_filter(c);
        return 1'b0;
    endfunction

    function automatic void close_line();
        if (hold_v && !skip_line) void'(comment_filter(hold_ch, 1'b0, '0));
        if (line_out) add_res(KIND_LINE, '0);
        hold_v = 1'b0;
        hold_ch = '0;
        skip_line = 1'b0;
        cq_open = 1'b0;
        sq_open = 1'b0;
        blank_sup = 1'b1;
        line_out = 1'b0;
    endfunction

    function automatic void strip_step(logic [CharW-1:0] b, logic eot);
        t_strip_res r;
        step_n = 0;
        if (eot) begin
            close_line();
            add_res(KIND_END, '0);
            reset_model();
        end else if (b == CH_CR || b == CH_LF) begin
            close_line();
        end else if (skip_line) begin
            // The rest of a line comment is dropped.
        end else if (hold_v) begin
            if (comment_filter(hold_ch, 1'b1, b)) begin
                hold_v = 1'b0;
                hold_ch = '0;
            end else begin
                hold_ch = b;
            end
        end else begin
            hold_v = 1'b1;
            hold_ch = b;
        end
        for (int i = 0; i < step_n; i++) begin
            r = step_res[i];
            r.last = (i == step_n - 1);
            strip_q = {strip_q, r};
        end
    endfunction

    task automatic send_req(input logic [CharW-1:0] b, input logic eot);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= eot;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        strip_step(b, eot);
        req_cnt++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_req(s[i], 1'b0);
    endtask

    function automatic logic [CharW-1:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 15) return CH_SPACE;
        if (r < 20) return CH_TAB;
        if (r < 30) return CH_SLASH;
        if (r < 38) return CH_STAR;
        if (r < 44) return CH_DQUOTE;
        if (r < 48) return CH_SQUOTE;
        if (r < 55) return CH_LF;
        if (r < 58) return CH_CR;
        if (r < 85) return 8'd97 + 8'($urandom_range(25));
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_req(pick_byte(), $urandom_range(59) == 0);
    endtask

    task automatic test_directed();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        send_text(" \t\"/*\" x /\n");
        send_text("/*//*/");
        send_req(CH_CR, 1'b0);
        send_text("*/");
        send_req(8'hFF, 1'b0);
        send_req(8'h00, 1'b0);
        send_text("\n\n*/a");
        send_req(8'hFF, 1'b1);
    endtask

    task automatic test_no_idle();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        send_random(80);
    endtask

    task automatic test_sender_idle();
        src_idle_pct = 87;
        sink_stall_pct = 0;
        send_random(80);
    endtask

    task automatic test_receiver_stall();
        src_idle_pct = 0;
        sink_stall_pct = 87;
        send_random(80);
    endtask

    task automatic test_both_idle();
        src_idle_pct = 20;
        sink_stall_pct = 20;
        send_random(80);
    endtask

    task automatic test_hold_off();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_req = 300;
        send_random(20);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        reset_model();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_hold_off();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (strip_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results under four idle mixes",
                 req_cnt, res_cnt);
        $display("and one long receiver hold-off that stalled the input stream.");
        if (fail_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

>>> c_comment_and_space_stripper.f
rtl/ccs_pkg.sv
rtl/ccs_core.sv
rtl/c_comment_and_space_stripper.sv
rtl/ccs_checker.sv
sim/tb.sv
